FILE: sv/okvt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package okvt_pkg;

  typedef enum logic [2:0] {
    MODE_INSERT           = 3'd0,
    MODE_UPDATE           = 3'd1,
    MODE_INSERT_OR_UPDATE = 3'd2,
    MODE_ERASE            = 3'd3,
    MODE_LOOKUP_KEY       = 3'd4,
    MODE_READ_POSITION    = 3'd5
  } mode_t;

  typedef struct packed {
    mode_t       mode;
    logic [31:0] req_key;
    logic [31:0] req_value;
    logic [3:0]  position;
  } okvt_req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] found_key;
    logic [31:0] found_value;
    logic [4:0]  entry_count;
  } okvt_rsp_t;

  // update commands broadcast to every cell when a pending transaction fires
  typedef struct packed {
    logic wr_hit;  // overwrite value in the selected cell
    logic ins;     // load key and value into the cell at the fill position
    logic ers;     // cells at or above the erased position take their upper neighbor
  } okvt_cmd_t;

endpackage

`default_nettype wire

FILE: sv/okvt_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module okvt_cell
  import okvt_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int IDX         = 0,
  localparam int IW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   capture,
  input  wire mode_t                  mode,
  input  wire logic [KEY_WIDTH-1:0]   req_key,
  input  wire logic [3:0]             position,
  input  wire logic [CW-1:0]          count,
  input  wire okvt_cmd_t              cmd,
  input  wire logic [IW-1:0]          idx,
  input  wire logic [KEY_WIDTH-1:0]   wr_key,
  input  wire logic [VALUE_WIDTH-1:0] wr_value,
  input  wire logic [KEY_WIDTH-1:0]   nbr_key,
  input  wire logic [VALUE_WIDTH-1:0] nbr_value,
  output logic [KEY_WIDTH-1:0]        key,
  output logic [VALUE_WIDTH-1:0]      value,
  output logic                        sel
);

  logic occupied;
  logic sel_next;

  assign occupied = CW'(IDX) < count;

  always_comb begin
    if (mode == MODE_READ_POSITION) begin
      sel_next = occupied && (IDX == int'(position));
    end else begin
      sel_next = occupied && (key == req_key);
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      sel <= sel_next;
    end
    if (cmd.ers && (IDX >= int'(idx))) begin
      key   <= nbr_key;
      value <= nbr_value;
    end else if (cmd.ins && (CW'(IDX) == count)) begin
      key   <= wr_key;
      value <= wr_value;
    end else if (cmd.wr_hit && sel) begin
      value <= wr_value;
    end
  end

endmodule

`default_nettype wire

FILE: sv/ordered_key_value_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Ordered key-value table: up to CAPACITY unique keys held packed in insertion order in a
// row of cells, one entry per cell. When a request is taken, every cell compares its key
// (or its position, for read_position) against the request at once and registers a hit
// flag; when the pending request fires, the table is updated (an erase shifts every cell
// above the hit down by one in that same cycle) and the result is loaded into the output
// register. A new request is not taken while one is pending; a stalled result holds off
// the next request only while it still sits in the output register and is not taken.

module ordered_key_value_table_core
  import okvt_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_stall,
  input  wire okvt_req_t req,
  output logic           rsp_valid,
  input  wire logic      rsp_stall,
  output okvt_rsp_t      rsp
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  logic                   pend;
  mode_t                  mode_q;
  logic [KEY_WIDTH-1:0]   key_q;
  logic [VALUE_WIDTH-1:0] value_q;
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;

  logic                   accept;
  logic                   fire;
  logic                   hit;
  logic                   full;
  logic                   ok_next;
  logic [IW-1:0]          idx;
  logic [KEY_WIDTH-1:0]   key_or;
  logic [VALUE_WIDTH-1:0] value_or;
  logic [KEY_WIDTH-1:0]   req_key_m;
  okvt_cmd_t              cmd;
  okvt_rsp_t              rsp_next;

  logic [CAPACITY-1:0]    sel;
  logic [KEY_WIDTH-1:0]   cell_key   [CAPACITY];
  logic [VALUE_WIDTH-1:0] cell_value [CAPACITY];

  assign req_stall = pend || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;
  assign fire      = pend && !(rsp_valid && rsp_stall);
  assign req_key_m = KEY_WIDTH'(req.req_key);
  assign full      = count == CW'(CAPACITY);
  assign hit       = |sel;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [KEY_WIDTH-1:0]   nbr_key;
    logic [VALUE_WIDTH-1:0] nbr_value;

    if (g == CAPACITY - 1) begin : g_top
      assign nbr_key   = '0;
      assign nbr_value = '0;
    end else begin : g_mid
      assign nbr_key   = cell_key[g+1];
      assign nbr_value = cell_value[g+1];
    end

    okvt_cell #(
      .CAPACITY   (CAPACITY),
      .KEY_WIDTH  (KEY_WIDTH),
      .VALUE_WIDTH(VALUE_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk      (clk),
      .capture  (accept),
      .mode     (req.mode),
      .req_key  (req_key_m),
      .position (req.position),
      .count    (count),
      .cmd      (cmd),
      .idx      (idx),
      .wr_key   (key_q),
      .wr_value (value_q),
      .nbr_key  (nbr_key),
      .nbr_value(nbr_value),
      .key      (cell_key[g]),
      .value    (cell_value[g]),
      .sel      (sel[g])
    );
  end

  // at most one cell is selected, so plain or-trees give its index and contents
  always_comb begin
    idx      = '0;
    key_or   = '0;
    value_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      idx      = idx | (sel[i] ? IW'(i) : '0);
      key_or   = key_or | (sel[i] ? cell_key[i] : '0);
      value_or = value_or | (sel[i] ? cell_value[i] : '0);
    end
  end

  always_comb begin
    cmd        = '0;
    ok_next    = 1'b0;
    count_next = count;
    rsp_next   = '0;
    rsp_next.found_key = 32'(key_q);
    unique case (mode_q)
      MODE_INSERT: begin
        ok_next = !hit && !full;
        cmd.ins = fire && ok_next;
      end
      MODE_UPDATE: begin
        ok_next    = hit;
        cmd.wr_hit = fire && hit;
      end
      MODE_INSERT_OR_UPDATE: begin
        ok_next    = hit || !full;
        cmd.wr_hit = fire && hit;
        cmd.ins    = fire && !hit && !full;
      end
      MODE_ERASE: begin
        ok_next = hit;
        cmd.ers = fire && hit;
      end
      MODE_LOOKUP_KEY: begin
        ok_next              = hit;
        rsp_next.found_value = 32'(value_or);
      end
      MODE_READ_POSITION: begin
        ok_next              = hit;
        rsp_next.found_key   = 32'(key_or);
        rsp_next.found_value = 32'(value_or);
      end
      default: begin
        ok_next = 1'b0;
      end
    endcase
    if (cmd.ins) begin
      count_next = count + CW'(1);
    end else if (cmd.ers) begin
      count_next = count - CW'(1);
    end
    rsp_next.ok          = ok_next;
    rsp_next.entry_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      rsp_valid <= 1'b0;
      count     <= '0;
    end else begin
      if (accept) begin
        pend <= 1'b1;
      end else if (fire) begin
        pend <= 1'b0;
      end
      if (fire) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_q  <= req.mode;
      key_q   <= req_key_m;
      value_q <= VALUE_WIDTH'(req.req_value);
    end
    if (fire) begin
      rsp <= rsp_next;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_sel_unique: assert property (@(posedge clk) disable iff (rst)
    pend |-> $onehot0(sel))
    else $error("more than one cell selected");

  a_accept_pend: assert property (@(posedge clk) disable iff (rst)
    accept |=> pend)
    else $error("accepted transaction not pending");

  a_rsp_from_pend: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(pend))
    else $error("result without pending transaction");
`endif

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import okvt_pkg::*;

  localparam int DEPTH = 16;
  localparam int RANDOM_ITEMS = 1900;
  localparam int IDLE_LIMIT = 2000;
  localparam int PRESSURE_AT = 60;
  localparam int PRESSURE_HOLD = 50;
  localparam int POOL_SIZE = 24;

  // modes six and seven are not decoded by the block
  localparam mode_t MODE_SPARE_6 = mode_t'(3'd6);
  localparam mode_t MODE_SPARE_7 = mode_t'(3'd7);

  typedef struct {
    okvt_req_t rq;
    int        reps;
    bit        typed;
    okvt_rsp_t want;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      req_valid = 1'b0;
  logic      req_stall;
  okvt_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_stall = 1'b0;
  okvt_rsp_t rsp;

  // shadow copy of the table
  logic [31:0] shadow_key [DEPTH];
  logic [31:0] shadow_val [DEPTH];
  int          held = 0;

  okvt_rsp_t   expected_q [$];
  okvt_rsp_t   rsp_want;
  script_row_t script [$];
  logic [31:0] key_pool [POOL_SIZE];
  int          mismatches = 0;
  int          rsp_seen = 0;
  int          sent = 0;
  bit          calm = 1'b0;

  ordered_key_value_table_core dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // apply one request to the shadow table and return what the block should answer
  function automatic okvt_rsp_t table_apply(okvt_req_t r);
    okvt_rsp_t res;
    int hit;
    hit = -1;
    for (int i = 0; i < held; i++) begin
      if (hit < 0 && shadow_key[i] == r.req_key) hit = i;
    end
    res.ok = 1'b0;
    res.found_key = r.req_key;
    res.found_value = '0;
    case (r.mode)
      MODE_INSERT, MODE_INSERT_OR_UPDATE: begin
        if (hit >= 0) begin
          if (r.mode == MODE_INSERT_OR_UPDATE) begin
            shadow_val[hit] = r.req_value;
            res.ok = 1'b1;
          end
        end else if (held < DEPTH) begin
          shadow_key[held] = r.req_key;
          shadow_val[held] = r.req_value;
          held++;
          res.ok = 1'b1;
        end
      end
      MODE_UPDATE: begin
        if (hit >= 0) begin
          shadow_val[hit] = r.req_value;
          res.ok = 1'b1;
        end
      end
      MODE_ERASE: begin
        if (hit >= 0) begin
          // close the gap so insertion order is kept
          for (int i = hit; i < held - 1; i++) begin
            shadow_key[i] = shadow_key[i + 1];
            shadow_val[i] = shadow_val[i + 1];
          end
          held--;
          res.ok = 1'b1;
        end
      end
      MODE_LOOKUP_KEY: begin
        if (hit >= 0) begin
          res.found_value = shadow_val[hit];
          res.ok = 1'b1;
        end
      end
      MODE_READ_POSITION: begin
        if (int'(r.position) < held) begin
          res.found_key = shadow_key[r.position];
          res.found_value = shadow_val[r.position];
          res.ok = 1'b1;
        end else begin
          res.found_key = '0;
        end
      end
      default: begin
      end
    endcase
    res.entry_count = 5'(held);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic script_row_t row(mode_t m, logic [31:0] k, logic [31:0] v,
                                      logic [3:0] p, int reps, bit typed, logic ok,
                                      logic [31:0] fk, logic [31:0] fv, logic [4:0] cnt);
    script_row_t s;
    s.rq.mode = m;
    s.rq.req_key = k;
    s.rq.req_value = v;
    s.rq.position = p;
    s.reps = reps;
    s.typed = typed;
    s.want.ok = ok;
    s.want.found_key = fk;
    s.want.found_value = fv;
    s.want.entry_count = cnt;
    return s;
  endfunction

  // fill phases lean on inserts, drain phases on erases
  function automatic okvt_req_t random_request(bit filling);
    okvt_req_t r;
    int pick;
    int ins_hi, iou_hi, upd_hi, ers_hi, lkp_hi, rd_hi;
    pick = $urandom_range(0, 99);
    ins_hi = filling ? 30 : 10;
    iou_hi = ins_hi + (filling ? 15 : 5);
    upd_hi = iou_hi + 10;
    ers_hi = upd_hi + (filling ? 10 : 35);
    lkp_hi = ers_hi + 15;
    rd_hi = lkp_hi + 15;
    if (pick < ins_hi) r.mode = MODE_INSERT;
    else if (pick < iou_hi) r.mode = MODE_INSERT_OR_UPDATE;
    else if (pick < upd_hi) r.mode = MODE_UPDATE;
    else if (pick < ers_hi) r.mode = MODE_ERASE;
    else if (pick < lkp_hi) r.mode = MODE_LOOKUP_KEY;
    else if (pick < rd_hi) r.mode = MODE_READ_POSITION;
    else if (pick[0]) r.mode = MODE_SPARE_6;
    else r.mode = MODE_SPARE_7;
    r.req_key = ($urandom_range(0, 9) < 8) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                            : $urandom;
    r.req_value = $urandom;
    r.position = 4'($urandom_range(0, 15));
    return r;
  endfunction

  // offer one transaction, wait for the handshake, then record the expected answer
  task automatic push_request(input okvt_req_t item, input bit typed, input okvt_rsp_t want);
    int gap;
    okvt_rsp_t predicted;
    calm = (sent >= 40 && sent < 200) || (sent % 256 >= 192);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = table_apply(item);
    expected_q.push_back(typed ? want : predicted);
    sent++;
  endtask

  // result side: random stalls plus one long hold-off to back the block up
  initial begin
    int hold;
    bit pressed;
    pressed = 1'b0;
    forever begin
      if (!pressed && rsp_seen >= PRESSURE_AT) begin
        pressed = 1'b1;
        hold = PRESSURE_HOLD;
      end else begin
        hold = pick_gap();
      end
      if (hold > 0) begin
        @(negedge clk);
        rsp_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk);
      rsp_stall <= 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_seen++;
      if (expected_q.size() == 0) begin
        $error("result transaction with nothing outstanding: key %h", rsp.found_key);
        mismatches++;
      end else begin
        rsp_want = expected_q.pop_front();
        if (rsp.ok !== rsp_want.ok) begin
          $error("ok: expected %0d, got %0d", rsp_want.ok, rsp.ok);
          mismatches++;
        end
        if (rsp.found_key !== rsp_want.found_key) begin
          $error("found_key: expected %h, got %h", rsp_want.found_key, rsp.found_key);
          mismatches++;
        end
        if (rsp.found_value !== rsp_want.found_value) begin
          $error("found_value: expected %h, got %h", rsp_want.found_value, rsp.found_value);
          mismatches++;
        end
        if (rsp.entry_count !== rsp_want.entry_count) begin
          $error("entry_count: expected %0d, got %0d", rsp_want.entry_count,
                 rsp.entry_count);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle = 0;
      else idle++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    okvt_req_t item;
    okvt_rsp_t none;
    none = '0;
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // empty table, extremes, unused modes, full table, erase down to an empty table
    script.push_back(row(MODE_LOOKUP_KEY, 32'h0, 32'h0, 4'd0, 1, 1'b1,
                         1'b0, 32'h0, 32'h0, 5'd0));
    script.push_back(row(MODE_READ_POSITION, 32'h1234_5678, 32'h0, 4'd0, 1, 1'b1,
                         1'b0, 32'h0, 32'h0, 5'd0));
    script.push_back(row(MODE_ERASE, 32'hFFFF_FFFF, 32'h0, 4'd0, 1, 1'b1,
                         1'b0, 32'hFFFF_FFFF, 32'h0, 5'd0));
    script.push_back(row(MODE_UPDATE, 32'h5, 32'h9, 4'd0, 1, 1'b1,
                         1'b0, 32'h5, 32'h0, 5'd0));
    script.push_back(row(MODE_INSERT, 32'h0, 32'hFFFF_FFFF, 4'd0, 1, 1'b1,
                         1'b1, 32'h0, 32'h0, 5'd1));
    script.push_back(row(MODE_INSERT, 32'hFFFF_FFFF, 32'h0, 4'd0, 1, 1'b1,
                         1'b1, 32'hFFFF_FFFF, 32'h0, 5'd2));
    script.push_back(row(MODE_INSERT, 32'h0, 32'h3, 4'd0, 1, 1'b1,
                         1'b0, 32'h0, 32'h0, 5'd2));
    script.push_back(row(MODE_READ_POSITION, 32'h0, 32'h0, 4'd1, 1, 1'b1,
                         1'b1, 32'hFFFF_FFFF, 32'h0, 5'd2));
    script.push_back(row(MODE_LOOKUP_KEY, 32'h0, 32'h0, 4'd0, 1, 1'b1,
                         1'b1, 32'h0, 32'hFFFF_FFFF, 5'd2));
    script.push_back(row(MODE_UPDATE, 32'h0, 32'h1234, 4'd0, 1, 1'b1,
                         1'b1, 32'h0, 32'h0, 5'd2));
    script.push_back(row(MODE_INSERT_OR_UPDATE, 32'hFFFF_FFFF, 32'h55, 4'd0, 1, 1'b1,
                         1'b1, 32'hFFFF_FFFF, 32'h0, 5'd2));
    script.push_back(row(MODE_INSERT_OR_UPDATE, 32'h7, 32'h77, 4'd0, 1, 1'b1,
                         1'b1, 32'h7, 32'h0, 5'd3));
    script.push_back(row(MODE_SPARE_6, 32'h9, 32'h1, 4'd0, 1, 1'b1,
                         1'b0, 32'h9, 32'h0, 5'd3));
    script.push_back(row(MODE_SPARE_7, 32'hA5A5_A5A5, 32'hFFFF_FFFF, 4'd15, 1, 1'b1,
                         1'b0, 32'hA5A5_A5A5, 32'h0, 5'd3));
    script.push_back(row(MODE_READ_POSITION, 32'hFFFF_FFFF, 32'h0, 4'd15, 1, 1'b1,
                         1'b0, 32'h0, 32'h0, 5'd3));
    script.push_back(row(MODE_ERASE, 32'h0, 32'h0, 4'd0, 1, 1'b1,
                         1'b1, 32'h0, 32'h0, 5'd2));
    script.push_back(row(MODE_READ_POSITION, 32'h0, 32'h0, 4'd0, 1, 1'b0,
                         1'b0, 32'h0, 32'h0, 5'd0));
    script.push_back(row(MODE_INSERT, 32'h100, 32'h5000, 4'd0, 14, 1'b0,
                         1'b0, 32'h0, 32'h0, 5'd0));
    script.push_back(row(MODE_INSERT, 32'hDEAD_0000, 32'h1, 4'd0, 1, 1'b1,
                         1'b0, 32'hDEAD_0000, 32'h0, 5'd16));
    script.push_back(row(MODE_INSERT_OR_UPDATE, 32'hDEAD_0001, 32'h2, 4'd0, 1, 1'b1,
                         1'b0, 32'hDEAD_0001, 32'h0, 5'd16));
    script.push_back(row(MODE_INSERT_OR_UPDATE, 32'h7, 32'h0, 4'd0, 1, 1'b1,
                         1'b1, 32'h7, 32'h0, 5'd16));
    script.push_back(row(MODE_READ_POSITION, 32'h0, 32'h0, 4'd15, 1, 1'b0,
                         1'b0, 32'h0, 32'h0, 5'd0));
    script.push_back(row(MODE_ERASE, 32'h100, 32'h0, 4'd0, 14, 1'b0,
                         1'b0, 32'h0, 32'h0, 5'd0));
    script.push_back(row(MODE_ERASE, 32'hFFFF_FFFF, 32'h0, 4'd0, 1, 1'b1,
                         1'b1, 32'hFFFF_FFFF, 32'h0, 5'd1));
    script.push_back(row(MODE_ERASE, 32'h7, 32'h0, 4'd0, 1, 1'b1,
                         1'b1, 32'h7, 32'h0, 5'd0));
    script.push_back(row(MODE_LOOKUP_KEY, 32'h7, 32'h0, 4'd0, 1, 1'b1,
                         1'b0, 32'h7, 32'h0, 5'd0));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (script[r]) begin
      for (int k = 0; k < script[r].reps; k++) begin
        item = script[r].rq;
        item.req_key = item.req_key + 32'(k);
        item.req_value = item.req_value + 32'(k);
        push_request(item, script[r].typed, script[r].want);
      end
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      push_request(random_request(((n / 64) % 2) == 0), 1'b0, none);
    end
    @(negedge clk);
    req_valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
